// ===== sv/cfsr_pkg.sv =====
// Shared types, constants and helper functions for the CAN frame subscription router.
package cfsr_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 2032;
	localparam int unsigned ID_W = 11;
	localparam int unsigned CHAN_W = 3;
	localparam int unsigned DLC_W = 4;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned NUM_CHANNELS = 5;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CHAN_W-1:0] HOST_CHANNEL = 3'd0;
	localparam logic [NUM_CHANNELS-1:0] HOST_MASK = 5'b00001;

	typedef logic [NUM_CHANNELS-1:0] chan_mask_t;

	typedef struct packed {
		logic [ID_W-1:0]   frame_id;
		logic [DLC_W-1:0]  length_code;
		logic [DATA_W-1:0] payload;
		chan_mask_t        fanout;
	} fwd_req_t;

	function automatic chan_mask_t chan_bit(input logic [CHAN_W-1:0] chan);
		chan_mask_t m;
		m = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			m[c] = (chan == CHAN_W'(c));
		end
		return m;
	endfunction

	function automatic logic [CHAN_W-1:0] lowest_chan(input chan_mask_t mask);
		logic [CHAN_W-1:0] ch;
		ch = HOST_CHANNEL;
		for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
			if (mask[c]) begin
				ch = CHAN_W'(c);
			end
		end
		return ch;
	endfunction

endpackage

// ===== sv/cfsr_front.sv =====
// Front end: accepts requests, keeps the destination mask table and builds fan-out requests.
module cfsr_front #(
	parameter int unsigned TABLE_ENTRIES = cfsr_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cfsr_pkg::ID_W-1:0]       frame_id,
	input  logic                            remote_request,
	input  logic [cfsr_pkg::CHAN_W-1:0]     arrival_channel,
	input  logic [cfsr_pkg::DLC_W-1:0]      length_code,
	input  logic [cfsr_pkg::DATA_W-1:0]     payload_in,
	output logic                            push,
	output cfsr_pkg::fwd_req_t              push_data,
	input  logic                            full
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP
	} state_t;

	state_t                       st_q;
	logic [IDX_W-1:0]             clr_q;
	logic                         remote_q;
	logic [IDX_W-1:0]             addr_q;
	logic [cfsr_pkg::CHAN_W-1:0]  chan_q;
	logic [cfsr_pkg::ID_W-1:0]    id_q;
	logic [cfsr_pkg::DLC_W-1:0]   dlc_q;
	logic [cfsr_pkg::DATA_W-1:0]  payload_q;
	cfsr_pkg::chan_mask_t         rdata_q;
	cfsr_pkg::chan_mask_t         mask_mem [TABLE_ENTRIES];

	logic                         accept;
	logic                         in_range;
	logic                         rd_en;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	cfsr_pkg::chan_mask_t         wr_data;
	cfsr_pkg::chan_mask_t         fanout;

	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = ({1'b0, frame_id} < 12'(TABLE_ENTRIES));
	assign rd_en    = accept && in_range;

	assign fanout  = rdata_q & ~cfsr_pkg::chan_bit(chan_q);
	assign wr_en   = (st_q == S_CLEAR) || ((st_q == S_LOOKUP) && remote_q);
	assign wr_addr = (st_q == S_CLEAR) ? clr_q : addr_q;
	assign wr_data = (st_q == S_CLEAR) ? cfsr_pkg::HOST_MASK
		: (rdata_q | cfsr_pkg::chan_bit(chan_q));

	assign push = (st_q == S_LOOKUP) && !remote_q && (fanout != '0) && !full;

	always_comb begin
		push_data.frame_id    = id_q;
		push_data.length_code = dlc_q;
		push_data.payload     = payload_q;
		push_data.fanout      = fanout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			clr_q    <= '0;
			remote_q <= 1'b0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (rd_en) begin
						remote_q <= remote_request;
						st_q     <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (remote_q || (fanout == '0) || !full) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q    <= frame_id[IDX_W-1:0];
			chan_q    <= arrival_channel;
			id_q      <= frame_id;
			dlc_q     <= length_code;
			payload_q <= payload_in;
			rdata_q   <= mask_mem[frame_id[IDX_W-1:0]];
		end
		if (wr_en) begin
			mask_mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== sv/cfsr_fifo.sv =====
// Short queue of fan-out requests between front and back end.
module cfsr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cfsr_pkg::fwd_req_t push_data,
	output logic               full,
	input  logic               pop,
	output cfsr_pkg::fwd_req_t pop_data,
	output logic               empty
);

	localparam int unsigned PTR_W = $clog2(cfsr_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(cfsr_pkg::QUEUE_DEPTH + 1);

	cfsr_pkg::fwd_req_t entry_q [cfsr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(cfsr_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/cfsr_back.sv =====
// Back end: walks each fan-out mask in channel order and emits one copy per cycle unless stalled.
module cfsr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         pop,
	input  cfsr_pkg::fwd_req_t           pop_data,
	input  logic                         empty,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cfsr_pkg::CHAN_W-1:0]  target_channel,
	output logic [cfsr_pkg::ID_W-1:0]    frame_id_out,
	output logic [cfsr_pkg::DLC_W-1:0]   length_code_out,
	output logic [cfsr_pkg::DATA_W-1:0]  payload_out,
	output logic                         last_copy
);

	cfsr_pkg::fwd_req_t           cur_q;
	cfsr_pkg::chan_mask_t         rem_q;
	logic                         out_valid_q;
	logic [cfsr_pkg::CHAN_W-1:0]  target_q;
	logic                         last_q;
	logic [cfsr_pkg::ID_W-1:0]    id_q;
	logic [cfsr_pkg::DLC_W-1:0]   dlc_q;
	logic [cfsr_pkg::DATA_W-1:0]  payload_q;

	logic [cfsr_pkg::CHAN_W-1:0]  low_chan;
	cfsr_pkg::chan_mask_t         rem_after;
	cfsr_pkg::chan_mask_t         rem_nx;
	logic                         load;

	assign low_chan  = cfsr_pkg::lowest_chan(rem_q);
	assign rem_after = rem_q & ~cfsr_pkg::chan_bit(low_chan);
	assign load      = (rem_q != '0) && (!out_valid_q || !out_stall);
	assign rem_nx    = load ? rem_after : rem_q;
	assign pop       = (rem_nx == '0) && !empty;

	assign out_valid       = out_valid_q;
	assign target_channel  = target_q;
	assign frame_id_out    = id_q;
	assign length_code_out = dlc_q;
	assign payload_out     = payload_q;
	assign last_copy       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rem_q <= pop ? pop_data.fanout : rem_nx;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (load) begin
			target_q  <= low_chan;
			last_q    <= (rem_after == '0);
			id_q      <= cur_q.frame_id;
			dlc_q     <= cur_q.length_code;
			payload_q <= cur_q.payload;
		end
	end

endmodule

// ===== sv/can_frame_subscription_router_top.sv =====
// Top level of the CAN frame subscription router.
// After reset the destination mask table is cleared to host-only in one pass
// over all TABLE_ENTRIES entries, during which in_stall stays high. Each
// accepted request then holds the front end through the lookup state (table
// lookup, and update for a remote request), longer while the queue is full;
// requests with an identifier at or above TABLE_ENTRIES are dropped without
// a lookup. Copies of a data frame leave the back end one per cycle in channel
// order while out_stall is low. A two-entry queue lets the front end run
// ahead of a stalled output.
module can_frame_subscription_router_top #(
	parameter int unsigned TABLE_ENTRIES = cfsr_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cfsr_pkg::ID_W-1:0]    frame_id,
	input  logic                         remote_request,
	input  logic [cfsr_pkg::CHAN_W-1:0]  arrival_channel,
	input  logic [cfsr_pkg::DLC_W-1:0]   length_code,
	input  logic [cfsr_pkg::DATA_W-1:0]  payload_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cfsr_pkg::CHAN_W-1:0]  target_channel,
	output logic [cfsr_pkg::ID_W-1:0]    frame_id_out,
	output logic [cfsr_pkg::DLC_W-1:0]   length_code_out,
	output logic [cfsr_pkg::DATA_W-1:0]  payload_out,
	output logic                         last_copy
);

	logic               push;
	cfsr_pkg::fwd_req_t push_data;
	logic               full;
	logic               pop;
	cfsr_pkg::fwd_req_t pop_data;
	logic               empty;

	cfsr_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.frame_id        (frame_id),
		.remote_request  (remote_request),
		.arrival_channel (arrival_channel),
		.length_code     (length_code),
		.payload_in      (payload_in),
		.push            (push),
		.push_data       (push_data),
		.full            (full)
	);

	cfsr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cfsr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop             (pop),
		.pop_data        (pop_data),
		.empty           (empty),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.target_channel  (target_channel),
		.frame_id_out    (frame_id_out),
		.length_code_out (length_code_out),
		.payload_out     (payload_out),
		.last_copy       (last_copy)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from empty queue");

	a_copies_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_copy) |=> out_valid)
		else $error("copy sequence broken before last copy");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (target_channel < 3'd5))
		else $error("target channel out of range");
`endif

endmodule
